// ===== rtl/ptt_pkg.sv =====
// package for the periodic timer table: request/result structs, slot record,
// command, status and state codes
// no dependencies
package ptt_pkg;

  localparam int SLOTS        = 32;
  localparam int SIGNAL_COUNT = 64;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [30:0] OVR_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    CMD_CREATE  = 4'd0,
    CMD_DELETE  = 4'd1,
    CMD_CLEANUP = 4'd2,
    CMD_SETTIME = 4'd3,
    CMD_GETTIME = 4'd4,
    CMD_GETOVR  = 4'd5,
    CMD_TICK    = 4'd6,
    CMD_NDONE   = 4'd7,
    CMD_NFAIL   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSLOT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_DIV1,
    S_DIV2,
    S_NOTE,
    S_CLOSE
  } state_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  owner;
    logic [31:0] tid;
    logic        use_rtc;
    logic        notify_signal;
    logic [5:0]  signal_number;
    logic [63:0] signal_value;
    logic        absolute;
    logic [63:0] value;
    logic [63:0] interval;
    logic [63:0] mono_now;
    logic [63:0] wall_ns;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] timer_id_out;
    logic [63:0] remaining;
    logic [63:0] interval_out;
    logic [30:0] overrun;
    logic [7:0]  owner_out;
    logic [5:0]  signal_out;
    logic [63:0] signal_value_out;
    logic        is_notification;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [23:0] generation;
    logic        use_rtc;
    logic        notify_signal;
    logic [5:0]  signal_number;
    logic [63:0] signal_value;
    logic [63:0] expiry;
    logic [63:0] period;
    logic [30:0] overrun;
    logic [30:0] ovr_accum;
    logic        armed;
    logic        rtc_abs;
    logic        notify_pending;
    logic        notify_retry;
  } rec_t;

endpackage

// ===== rtl/periodic_timer_table.sv =====
// periodic_timer_table: a request rejected on its fields is answered from idle; id
// commands pass read and evaluate states, repeated per slot scanned for create/cleanup;
// tick adds a note state per slot, two 64-step restoring divisions per expired periodic
// slot (one quotient bit per cycle) and a closing state. throughput: one request at a
// time, busy drops as the last result goes out. synchronous active-high reset clears
// control state, slot valid bits; unwritten slots read as all zero; results never stall
module periodic_timer_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ptt_pkg::req_t   req,
  output logic            done,
  output ptt_pkg::rsp_t   rsp
);

  ptt_pkg::state_t state, state_next;
  logic [ptt_pkg::SLOT_W-1:0] idx, idx_next;
  ptt_pkg::req_t rq, rq_next;
  ptt_pkg::rec_t wr, wr_next;
  logic [63:0] missed, missed_next;
  logic [63:0] rem1, rem1_next;
  logic [63:0] dq, dq_next;
  logic [63:0] drem, drem_next;
  logic [5:0]  dcnt, dcnt_next;
  logic        done_next;
  ptt_pkg::rsp_t rsp_next;

  // slot memory
  ptt_pkg::rec_t mem [ptt_pkg::SLOTS];
  logic [ptt_pkg::SLOTS-1:0] vld;
  ptt_pkg::rec_t rd, cur, wdata;
  logic rd_vld, we;

  logic [7:0]  in_enc;
  logic        in_fmt_ok, sig_bad, match, last_slot;
  logic [63:0] tnow, wnow, tleft;
  logic [64:0] r2;
  logic        ge;
  logic [63:0] rn, dq_step;
  logic [30:0] min_m, dec_m;
  logic [31:0] sum_m;
  logic [63:0] m1;
  logic [23:0] gen_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[idx];
      if (we) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  assign cur = rd_vld ? rd : '0;

  assign in_enc    = req.tid[7:0];
  assign in_fmt_ok = (req.owner != 8'd0) && (in_enc != 8'd0) &&
                     ((in_enc - 8'd1) < 8'(ptt_pkg::SLOTS));
  assign sig_bad   = req.notify_signal && ((req.signal_number == 6'd0) ||
                     ({2'b00, req.signal_number} >= 8'(ptt_pkg::SIGNAL_COUNT)));
  assign match     = (cur.owner == rq.owner) && (cur.generation == rq.tid[31:8]);
  assign last_slot = (idx == ptt_pkg::SLOT_W'(ptt_pkg::SLOTS - 1));
  assign tnow      = cur.rtc_abs ? rq.wall_ns : rq.mono_now;
  assign wnow      = wr.rtc_abs ? rq.wall_ns : rq.mono_now;
  assign tleft     = (cur.armed && (tnow < cur.expiry)) ? (cur.expiry - tnow) : 64'd0;
  assign gen_inc   = (cur.generation + 24'd1 == 24'd0) ? 24'd1 : cur.generation + 24'd1;

  // one restoring divider step
  assign r2      = {drem, dq[63]};
  assign ge      = r2 >= {1'b0, wr.period};
  assign rn      = ge ? (r2[63:0] - wr.period) : r2[63:0];
  assign dq_step = {dq[62:0], ge};

  // overrun saturation
  assign min_m = (missed > {33'd0, ptt_pkg::OVR_MAX}) ? ptt_pkg::OVR_MAX : missed[30:0];
  assign sum_m = {1'b0, wr.ovr_accum} + {1'b0, min_m};
  assign m1    = missed - 64'd1;
  assign dec_m = (m1 > {33'd0, ptt_pkg::OVR_MAX}) ? ptt_pkg::OVR_MAX : m1[30:0];

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    rq_next     = rq;
    wr_next     = wr;
    missed_next = missed;
    rem1_next   = rem1;
    dq_next     = dq;
    drem_next   = drem;
    dcnt_next   = dcnt;
    done_next   = 1'b0;
    rsp_next    = '0;
    rsp_next.last = 1'b1;
    we          = 1'b0;
    wdata       = cur;
    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (start) begin
          rq_next  = req;
          idx_next = '0;
          case (req.cmd) inside
            ptt_pkg::CMD_CREATE: begin
              if (req.owner == 8'd0 || sig_bad) begin
                done_next = 1'b1;
                rsp_next.status = ptt_pkg::ST_INVALID;
              end else begin
                state_next = ptt_pkg::S_RD;
              end
            end
            ptt_pkg::CMD_CLEANUP: begin
              if (req.owner == 8'd0) begin
                done_next = 1'b1;
                rsp_next.status = ptt_pkg::ST_INVALID;
              end else begin
                state_next = ptt_pkg::S_RD;
              end
            end
            ptt_pkg::CMD_TICK: begin
              state_next = ptt_pkg::S_RD;
            end
            ptt_pkg::CMD_DELETE, ptt_pkg::CMD_SETTIME, ptt_pkg::CMD_GETTIME,
            ptt_pkg::CMD_GETOVR, ptt_pkg::CMD_NDONE, ptt_pkg::CMD_NFAIL: begin
              if (in_fmt_ok) begin
                idx_next   = ptt_pkg::SLOT_W'(in_enc - 8'd1);
                state_next = ptt_pkg::S_RD;
              end else begin
                done_next = 1'b1;
                rsp_next.status = ptt_pkg::ST_INVALID;
              end
            end
            default: begin
              done_next = 1'b1;
              rsp_next.status = ptt_pkg::ST_INVALID;
            end
          endcase
        end
      end

      ptt_pkg::S_RD: begin
        state_next = ptt_pkg::S_EV;
      end

      ptt_pkg::S_EV: begin
        state_next = ptt_pkg::S_IDLE;
        case (rq.cmd) inside
          ptt_pkg::CMD_CREATE: begin
            if (cur.owner == 8'd0) begin
              we = 1'b1;
              wdata = '0;
              wdata.owner          = rq.owner;
              wdata.generation     = gen_inc;
              wdata.use_rtc        = rq.use_rtc;
              wdata.notify_signal  = rq.notify_signal;
              wdata.signal_number  = rq.signal_number;
              wdata.signal_value   = rq.signal_value;
              done_next = 1'b1;
              rsp_next.timer_id_out = {gen_inc, 8'(idx) + 8'd1};
            end else if (last_slot) begin
              done_next = 1'b1;
              rsp_next.status = ptt_pkg::ST_NOSLOT;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = ptt_pkg::S_RD;
            end
          end
          ptt_pkg::CMD_CLEANUP: begin
            if (cur.owner == rq.owner) begin
              we = 1'b1;
              wdata.owner          = 8'd0;
              wdata.armed          = 1'b0;
              wdata.notify_pending = 1'b0;
              wdata.notify_retry   = 1'b0;
            end
            if (last_slot) begin
              done_next = 1'b1;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = ptt_pkg::S_RD;
            end
          end
          ptt_pkg::CMD_TICK: begin
            wr_next     = cur;
            missed_next = 64'd0;
            state_next  = ptt_pkg::S_NOTE;
            if (cur.owner != 8'd0 && cur.armed && tnow >= cur.expiry) begin
              if (cur.period == 64'd0) begin
                missed_next   = 64'd1;
                wr_next.armed = 1'b0;
              end else begin
                dq_next    = tnow - cur.expiry;
                drem_next  = 64'd0;
                dcnt_next  = 6'd0;
                state_next = ptt_pkg::S_DIV1;
              end
            end
          end
          ptt_pkg::CMD_DELETE: begin
            done_next = 1'b1;
            if (match) begin
              we = 1'b1;
              wdata.owner          = 8'd0;
              wdata.armed          = 1'b0;
              wdata.notify_pending = 1'b0;
              wdata.notify_retry   = 1'b0;
            end else begin
              rsp_next.status = ptt_pkg::ST_INVALID;
            end
          end
          ptt_pkg::CMD_SETTIME: begin
            done_next = 1'b1;
            if (!match) begin
              rsp_next.status = ptt_pkg::ST_INVALID;
            end else if (rq.value != 64'd0 && !rq.absolute && rq.value > ~rq.mono_now) begin
              rsp_next.status = ptt_pkg::ST_OVERFLOW;
            end else begin
              we = 1'b1;
              wdata.expiry = (rq.value == 64'd0) ? 64'd0 :
                             (rq.absolute ? rq.value : rq.mono_now + rq.value);
              wdata.period = rq.interval;
              wdata.overrun = '0;
              wdata.rtc_abs = rq.absolute && cur.use_rtc;
              wdata.armed = (rq.value != 64'd0);
              rsp_next.remaining    = tleft;
              rsp_next.interval_out = cur.period;
            end
          end
          ptt_pkg::CMD_GETTIME: begin
            done_next = 1'b1;
            if (match) begin
              rsp_next.remaining    = tleft;
              rsp_next.interval_out = cur.period;
            end else begin
              rsp_next.status = ptt_pkg::ST_INVALID;
            end
          end
          ptt_pkg::CMD_GETOVR: begin
            done_next = 1'b1;
            if (match) begin
              rsp_next.overrun = cur.overrun;
            end else begin
              rsp_next.status = ptt_pkg::ST_INVALID;
            end
          end
          ptt_pkg::CMD_NDONE, ptt_pkg::CMD_NFAIL: begin
            done_next = 1'b1;
            if (match && cur.notify_pending) begin
              we = 1'b1;
              if (rq.cmd == ptt_pkg::CMD_NDONE) begin
                wdata.overrun        = cur.ovr_accum;
                wdata.ovr_accum      = '0;
                wdata.notify_retry   = 1'b0;
              end else begin
                wdata.notify_retry = 1'b1;
              end
              wdata.notify_pending = 1'b0;
            end else begin
              rsp_next.status = ptt_pkg::ST_INVALID;
            end
          end
          default: begin
            done_next = 1'b1;
            rsp_next.status = ptt_pkg::ST_INVALID;
          end
        endcase
      end

      ptt_pkg::S_DIV1: begin
        dq_next   = dq_step;
        drem_next = rn;
        dcnt_next = dcnt + 6'd1;
        if (dcnt == 6'd63) begin
          // missed periods; second pass bounds them against overflow
          missed_next = dq_step + 64'd1;
          rem1_next   = rn;
          dq_next     = ~wr.expiry;
          drem_next   = 64'd0;
          dcnt_next   = 6'd0;
          state_next  = ptt_pkg::S_DIV2;
        end
      end

      ptt_pkg::S_DIV2: begin
        dq_next   = dq_step;
        drem_next = rn;
        dcnt_next = dcnt + 6'd1;
        if (dcnt == 6'd63) begin
          if (missed > dq_step) begin
            wr_next.armed = 1'b0;
          end else if (missed != 64'd0) begin
            // exp + missed * period, with the division remainder taken back out
            wr_next.expiry = wnow - rem1 + wr.period;
          end
          state_next = ptt_pkg::S_NOTE;
        end
      end

      ptt_pkg::S_NOTE: begin
        wdata = wr;
        if (wr.owner != 8'd0) begin
          we = 1'b1;
          if (wr.notify_signal) begin
            if (missed != 64'd0) begin
              if (wr.notify_pending || wr.notify_retry) begin
                wdata.ovr_accum = sum_m[31] ? ptt_pkg::OVR_MAX : sum_m[30:0];
              end else begin
                wdata.ovr_accum = dec_m;
              end
            end
            if (!(wr.notify_pending || (!wr.notify_retry && missed == 64'd0))) begin
              wdata.notify_pending = 1'b1;
              wdata.notify_retry   = 1'b0;
              done_next = 1'b1;
              rsp_next.timer_id_out     = {wr.generation, 8'(idx) + 8'd1};
              rsp_next.overrun          = wdata.ovr_accum;
              rsp_next.owner_out        = wr.owner;
              rsp_next.signal_out       = wr.signal_number;
              rsp_next.signal_value_out = wr.signal_value;
              rsp_next.is_notification  = 1'b1;
              rsp_next.last             = 1'b0;
            end
          end
        end
        if (last_slot) begin
          state_next = ptt_pkg::S_CLOSE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ptt_pkg::S_RD;
        end
      end

      ptt_pkg::S_CLOSE: begin
        done_next  = 1'b1;
        state_next = ptt_pkg::S_IDLE;
      end

      default: begin
        state_next = ptt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::S_IDLE;
      done  <= 1'b0;
      idx   <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      idx   <= idx_next;
      dcnt  <= dcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rq     <= rq_next;
    wr     <= wr_next;
    missed <= missed_next;
    rem1   <= rem1_next;
    dq     <= dq_next;
    drem   <= drem_next;
    rsp    <= rsp_next;
  end

  assign busy = (state != ptt_pkg::S_IDLE);

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && rsp.last |-> !busy)
    else $error("closing result while still busy");

  a_mid_notify: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |-> rsp.is_notification)
    else $error("non-final result is not a notification");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (done && rsp.last))
    else $error("accepted request neither started nor answered");

  a_div_only: assert property (@(posedge clk) disable iff (rst)
    dcnt != 6'd0 |-> state == ptt_pkg::S_DIV1 || state == ptt_pkg::S_DIV2)
    else $error("divider count live outside division");

endmodule
